// ===== rtl/core/bhc_pkg.sv =====
// bhc_pkg: shared types and constants of the byte histogram compactor
// operation codes, payload structs and the controller/datapath command bundle
// no dependencies
`default_nettype none

package bhc_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_COMPACT = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
    logic [7:0] entry_index;
  } bhc_in_t;

  typedef struct packed {
    logic [7:0]  entry_symbol;
    logic [31:0] entry_count;
    logic [31:0] total_seen;
    logic [8:0]  distinct_seen;
    logic        accepted;
  } bhc_out_t;

  typedef struct packed {
    logic op_load;
    logic refuse;
    logic push_new;
    logic push_read;
    logic push_upd;
    logic rd_read;
    logic rd_capture;
    logic clear;
    logic cmp_init;
    logic cmp_step;
    logic cmp_done;
    logic out_load;
  } bhc_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       push_ok;
    logic       hit_sym;
    logic       idx_ok;
    logic       hit_idx;
    logic       cmp_last;
    logic       out_free;
  } bhc_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bhc_if.sv =====
// bhc_in_if, bhc_out_if: valid/ready channels of the byte histogram compactor
// the input channel carries one operation item, the output channel one result item
// no dependencies
`default_nettype none

interface bhc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;
  logic [7:0] entry_index;

  modport source (output valid, output func, output symbol, output entry_index,
                  input ready);
  modport sink (input valid, input func, input symbol, input entry_index,
                output ready);
endinterface

interface bhc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  entry_symbol;
  logic [31:0] entry_count;
  logic [31:0] total_seen;
  logic [8:0]  distinct_seen;
  logic        accepted;

  modport source (output valid, output entry_symbol, output entry_count,
                  output total_seen, output distinct_seen, output accepted,
                  input ready);
  modport sink (input valid, input entry_symbol, input entry_count,
                input total_seen, input distinct_seen, input accepted,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bhc_ram.sv =====
// bhc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bhc_ctrl.sv =====
// bhc_ctrl: sequencer of the byte histogram compactor
// steps each item through decode, table access and result load
// depends on bhc_pkg
`default_nettype none

module bhc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire bhc_pkg::bhc_status_t status_i,
  output      bhc_pkg::bhc_cmd_t    cmd_o
);
  import bhc_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_PUSH_UPD  = 3'd2;
  localparam logic [2:0] S_READ_DATA = 3'd3;
  localparam logic [2:0] S_CMP       = 3'd4;
  localparam logic [2:0] S_CMP_DRAIN = 3'd5;
  localparam logic [2:0] S_RESP      = 3'd6;

  logic [2:0] state_q, state_d;
  bhc_cmd_t   cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.op_load = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status_i.func)
          FUNC_PUSH: begin
            if (!status_i.push_ok) begin
              cmd.refuse = 1'b1;
              state_d    = S_RESP;
            end else if (status_i.hit_sym) begin
              cmd.push_read = 1'b1;
              state_d       = S_PUSH_UPD;
            end else begin
              cmd.push_new = 1'b1;
              state_d      = S_RESP;
            end
          end
          FUNC_COMPACT: begin
            cmd.cmp_init = 1'b1;
            state_d      = S_CMP;
          end
          FUNC_READ: begin
            if (status_i.idx_ok && status_i.hit_idx) begin
              cmd.rd_read = 1'b1;
              state_d     = S_READ_DATA;
            end else begin
              state_d = S_RESP;
            end
          end
          FUNC_CLEAR: begin
            cmd.clear = 1'b1;
            state_d   = S_RESP;
          end
        endcase
      end
      S_PUSH_UPD: begin
        cmd.push_upd = 1'b1;
        state_d      = S_RESP;
      end
      S_READ_DATA: begin
        cmd.rd_capture = 1'b1;
        state_d        = S_RESP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (status_i.cmp_last) begin
          state_d = S_CMP_DRAIN;
        end
      end
      S_CMP_DRAIN: begin
        cmd.cmp_done = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bhc_datapath.sv =====
// bhc_datapath: table ram, entry valid bits, totals and result register
// of the byte histogram compactor
// depends on bhc_pkg and bhc_ram
`default_nettype none

module bhc_datapath #(
  parameter int unsigned TABLE_SIZE = bhc_pkg::TABLE_SIZE_DEF,
  parameter int unsigned COUNT_BITS = bhc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bhc_pkg::bhc_in_t     in_data_i,
  input  wire bhc_pkg::bhc_cmd_t    cmd_i,
  output      bhc_pkg::bhc_status_t status_o,
  input  wire logic                 out_ready_i,
  output      logic                 out_valid_o,
  output      bhc_pkg::bhc_out_t    out_data_o
);
  import bhc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned WORD_W = COUNT_BITS + 8;

  logic [1:0]            op_func_q;
  logic [7:0]            op_sym_q;
  logic [7:0]            op_idx_q;
  logic [TABLE_SIZE-1:0] valid_q, valid_d;
  logic [31:0]           total_q, total_d;
  logic [8:0]            distinct_q, distinct_d;
  logic                  compacted_q, compacted_d;
  logic [IDX_W-1:0]      src_q, src_d;
  logic [IDX_W-1:0]      dst_q, dst_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pend_addr_q, pend_addr_d;
  logic [7:0]            res_sym_q;
  logic [31:0]           res_cnt_q;
  logic                  res_ok_q;
  logic                  out_valid_q;
  bhc_out_t              out_q;

  logic [IDX_W-1:0]      sym_idx, rd_idx;
  logic                  sym_ok, idx_ok;
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;
  logic [COUNT_BITS-1:0] rd_cnt, cnt_inc;
  logic [31:0]           total_inc;
  logic                  out_free;

  assign sym_idx   = op_sym_q[IDX_W-1:0];
  assign rd_idx    = op_idx_q[IDX_W-1:0];
  assign sym_ok    = {1'b0, op_sym_q} < 9'(TABLE_SIZE);
  assign idx_ok    = {1'b0, op_idx_q} < 9'(TABLE_SIZE);
  assign rd_cnt    = ram_rdata[COUNT_BITS-1:0];
  assign cnt_inc   = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign total_inc = (&total_q) ? total_q : total_q + 32'd1;
  assign out_free  = !out_valid_q || out_ready_i;

  assign status_o.func     = op_func_q;
  assign status_o.push_ok  = !compacted_q && sym_ok;
  assign status_o.hit_sym  = valid_q[sym_idx];
  assign status_o.idx_ok   = idx_ok;
  assign status_o.hit_idx  = valid_q[rd_idx];
  assign status_o.cmp_last = src_q == IDX_W'(TABLE_SIZE - 1);
  assign status_o.out_free = out_free;

  always_comb begin
    valid_d     = valid_q;
    total_d     = total_q;
    distinct_d  = distinct_q;
    compacted_d = compacted_q;
    src_d       = src_q;
    dst_d       = dst_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    ram_we      = 1'b0;
    ram_waddr   = sym_idx;
    ram_wdata   = {op_sym_q, COUNT_BITS'(1)};
    ram_re      = 1'b0;
    ram_raddr   = sym_idx;

    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end

    if (cmd_i.push_new) begin
      ram_we           = 1'b1;
      valid_d[sym_idx] = 1'b1;
      distinct_d       = distinct_q + 9'd1;
      total_d          = total_inc;
    end
    if (cmd_i.push_read) begin
      ram_re = 1'b1;
    end
    if (cmd_i.push_upd) begin
      ram_we    = 1'b1;
      ram_wdata = {ram_rdata[WORD_W-1:COUNT_BITS], cnt_inc};
      total_d   = total_inc;
    end
    if (cmd_i.rd_read) begin
      ram_re    = 1'b1;
      ram_raddr = rd_idx;
    end

    if (cmd_i.cmp_init) begin
      src_d = '0;
      dst_d = '0;
    end
    if (cmd_i.cmp_step) begin
      src_d = src_q + IDX_W'(1);
      if (valid_q[src_q]) begin
        dst_d = dst_q + IDX_W'(1);
        if (dst_q != src_q) begin
          // move entry down: read now, write next cycle
          ram_re         = 1'b1;
          ram_raddr      = src_q;
          pend_d         = 1'b1;
          pend_addr_d    = dst_q;
          valid_d[dst_q] = 1'b1;
          valid_d[src_q] = 1'b0;
        end
      end
    end
    if (cmd_i.cmp_done) begin
      compacted_d = 1'b1;
    end

    if (cmd_i.clear) begin
      valid_d     = '0;
      total_d     = '0;
      distinct_d  = '0;
      compacted_d = 1'b0;
    end
  end

  bhc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      total_q     <= '0;
      distinct_q  <= '0;
      compacted_q <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      total_q     <= total_d;
      distinct_q  <= distinct_d;
      compacted_q <= compacted_d;
      pend_q      <= pend_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    dst_q       <= dst_d;
    pend_addr_q <= pend_addr_d;
    if (cmd_i.op_load) begin
      op_func_q <= in_data_i.func;
      op_sym_q  <= in_data_i.symbol;
      op_idx_q  <= in_data_i.entry_index;
      res_sym_q <= '0;
      res_cnt_q <= '0;
      res_ok_q  <= 1'b1;
    end
    if (cmd_i.refuse) begin
      res_ok_q <= 1'b0;
    end
    if (cmd_i.rd_capture) begin
      res_sym_q <= ram_rdata[WORD_W-1:COUNT_BITS];
      res_cnt_q <= 32'(rd_cnt);
    end
    if (cmd_i.out_load) begin
      out_q.entry_symbol  <= res_sym_q;
      out_q.entry_count   <= res_cnt_q;
      out_q.total_seen    <= total_q;
      out_q.distinct_seen <= distinct_q;
      out_q.accepted      <= res_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/byte_histogram_compactor.sv =====
// byte_histogram_compactor: top level of the byte frequency histogram
// ties the sequencer and the datapath to the input and output channels
// depends on bhc_pkg, bhc_if, bhc_ctrl and bhc_datapath
`default_nettype none

// Counts byte occurrences for a Huffman front end. One item at a time: an
// item is taken from in_i, worked on, and its single result is placed in an
// output register on out_o, which frees the input side while it waits. Push of
// a new byte, a refused push, a read of an empty or out-of-range entry and a
// clear go from decode straight to the result load; a push of a byte already
// seen first reads its entry and then writes it back incremented through the
// one read and one write port of the table ram, and a read of a used entry
// reads and then captures it. Compaction sweeps the table once, one entry a
// cycle. Each entry has a valid bit in flip-flops, so reset and clear empty
// the table at once with no clearing pass.
module byte_histogram_compactor #(
  parameter int unsigned TABLE_SIZE = bhc_pkg::TABLE_SIZE_DEF,
  parameter int unsigned COUNT_BITS = bhc_pkg::COUNT_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bhc_in_if.sink     in_i,
  bhc_out_if.source  out_o
);
  import bhc_pkg::*;

  bhc_cmd_t    cmd;
  bhc_status_t status;
  bhc_in_t     in_data;
  bhc_out_t    out_data;
  logic        in_ready;
  logic        out_valid;

  assign in_data.func        = in_i.func;
  assign in_data.symbol      = in_i.symbol;
  assign in_data.entry_index = in_i.entry_index;
  assign in_i.ready          = in_ready;

  bhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bhc_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_o.valid         = out_valid;
  assign out_o.entry_symbol  = out_data.entry_symbol;
  assign out_o.entry_count   = out_data.entry_count;
  assign out_o.total_seen    = out_data.total_seen;
  assign out_o.distinct_seen = out_data.distinct_seen;
  assign out_o.accepted      = out_data.accepted;

endmodule

`default_nettype wire
